FILE: hdl/gas_pkg.sv
`timescale 1ns / 1ps

package gas_pkg;

	// command codes
	localparam logic [2:0] CMD_ADD_NODE   = 3'd0;
	localparam logic [2:0] CMD_REM_NODE   = 3'd1;
	localparam logic [2:0] CMD_ADD_EDGE   = 3'd2;
	localparam logic [2:0] CMD_REM_EDGE   = 3'd3;
	localparam logic [2:0] CMD_SET_COST   = 3'd4;
	localparam logic [2:0] CMD_QUERY_EDGE = 3'd5;
	localparam logic [2:0] CMD_QUERY_NODE = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_INDEX = 3'd1;
	localparam logic [2:0] ST_ACTIVE    = 3'd2;
	localparam logic [2:0] ST_ABSENT    = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_BAD_CMD   = 3'd5;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_FLEN,
		S_FLENW,
		S_FRD,
		S_FCMP,
		S_ERD,
		S_EWR,
		S_ELEN,
		S_NEXT,
		S_RNLEN,
		S_RNLENW,
		S_RNRD,
		S_RNCMP,
		S_RNEND,
		S_CLEN,
		S_CLENW,
		S_CRD,
		S_CCHK,
		S_CEND,
		S_DONE
	} gas_state_t;

	// where a command stands when a list search or erase hands back
	typedef enum logic [1:0] {
		PH_FIND1,
		PH_FIND2,
		PH_MID,
		PH_END
	} gas_phase_t;

endpackage

FILE: hdl/gas_ram.sv
`timescale 1ns / 1ps

module gas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/graph_adjacency_store.sv
`timescale 1ns / 1ps

// channel | direction | handshake             | payload
// --------+-----------+-----------------------+---------------------------------------------
// in      | in        | in_valid / in_ready   | command, node_a, node_b, edge_cost
// out     | out       | out_valid / out_ready | status, found, cost_out, node_total,
//         |           |                       | active_total, edge_total
// cfg     | in        | cfg_wr_en             | cfg_wr_data (directed)
//
// one command at a time; in_ready is high only while the sequencer is idle
// node commands and bad commands: decode, then done, where the result register is loaded
// once it is empty or out_ready is high; a valid remove node walks the lists first
// edge commands: each list search reads the list length, then reads and compares each
// scanned entry; an erase reads and writes back each shifted entry; both are bound by
// the single edge memory read port
// undirected node removal: one search and erase per neighbor
// directed node removal walks every allocated list
// arst_n clears the sequencer, valid bits and counters; a result beat waiting on
// out_ready does not stop the next command beat from being accepted

module graph_adjacency_store #(
	parameter int MAX_NODES          = 64,
	parameter int MAX_EDGES_PER_NODE = 8,
	parameter int COST_BITS          = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           command,
	input  logic [$clog2(MAX_NODES)-1:0] node_a,
	input  logic [$clog2(MAX_NODES)-1:0] node_b,
	input  logic [COST_BITS-1:0] edge_cost,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic                 found,
	output logic [COST_BITS-1:0] cost_out,
	output logic [$clog2(MAX_NODES+1)-1:0] node_total,
	output logic [$clog2(MAX_NODES+1)-1:0] active_total,
	output logic [$clog2(MAX_NODES*MAX_EDGES_PER_NODE+1)-1:0] edge_total
);

	localparam int NW  = $clog2(MAX_NODES);                          // node index
	localparam int CW  = $clog2(MAX_NODES + 1);                      // node count
	localparam int LW  = $clog2(MAX_EDGES_PER_NODE + 1);             // list length / position
	localparam int EA  = $clog2(MAX_NODES * MAX_EDGES_PER_NODE);     // edge memory address
	localparam int EW  = $clog2(MAX_NODES * MAX_EDGES_PER_NODE + 1); // edge count
	localparam int EDW = NW + COST_BITS;                             // target and cost word

	// slot of entry p in the list of node n
	function automatic logic [EA-1:0] eaddr(input logic [NW-1:0] n, input logic [LW-1:0] p);
		eaddr = EA'(n) * EA'(MAX_EDGES_PER_NODE) + EA'(p);
	endfunction

	gas_pkg::gas_state_t state_q, state_d;
	gas_pkg::gas_phase_t ph_q;

	// control state
	logic                 directed_q;
	logic [MAX_NODES-1:0] valid_q;
	logic [CW-1:0]        slots_q;
	logic [CW-1:0]        active_q;
	logic [EW-1:0]        edges_q;
	logic                 out_valid_q;

	// captured command
	logic [2:0]           cmd_q;
	logic [NW-1:0]        a_q;
	logic [NW-1:0]        b_q;
	logic [COST_BITS-1:0] c_q;

	// list search and erase unit
	logic [NW-1:0]        fn_node_q;
	logic [NW-1:0]        fn_key_q;
	logic [LW-1:0]        len_q;
	logic [LW-1:0]        i_q;
	logic [LW-1:0]        pos_q;
	logic                 hit_q;
	logic [COST_BITS-1:0] hitw_q;

	// per-command working registers
	logic                 need_fwd_q;
	logic                 need_rev_q;
	logic [LW-1:0]        len_a_q;
	logic [LW-1:0]        len_b_q;
	logic                 any_q;
	logic [LW-1:0]        j_q;
	logic [LW-1:0]        rn_len_q;
	logic [CW-1:0]        n_q;
	logic [LW-1:0]        keep_q;

	// working result and result register
	logic [2:0]           st_q;
	logic                 fnd_q;
	logic [COST_BITS-1:0] cst_q;
	logic [2:0]           status_q;
	logic                 found_q;
	logic [COST_BITS-1:0] cost_q;
	logic [CW-1:0]        node_total_q;
	logic [CW-1:0]        active_total_q;
	logic [EW-1:0]        edge_total_q;

	// memory ports
	logic                 len_we;
	logic [NW-1:0]        len_waddr;
	logic [LW-1:0]        len_wdata;
	logic [NW-1:0]        len_raddr;
	logic [LW-1:0]        len_rd;
	logic                 edge_we;
	logic [EA-1:0]        edge_waddr;
	logic [EDW-1:0]       edge_wdata;
	logic [EA-1:0]        edge_raddr;
	logic [EDW-1:0]       edge_rd;

	logic [NW-1:0]        rd_tgt;
	logic [COST_BITS-1:0] rd_wgt;
	logic                 a_ok, b_ok, va, vb;
	logic                 fresh_c, rev_c, full_c, hit_now, keep_c, load_out;

	assign rd_tgt   = edge_rd[EDW-1:COST_BITS];
	assign rd_wgt   = edge_rd[COST_BITS-1:0];
	assign a_ok     = CW'(a_q) < slots_q;
	assign b_ok     = CW'(b_q) < slots_q;
	assign va       = valid_q[a_q];
	assign vb       = valid_q[b_q];
	// add node may take exactly the next fresh slot
	assign fresh_c  = !a_ok && (CW'(a_q) == slots_q) && (slots_q < CW'(MAX_NODES));
	// mirror needed only for undirected, non-self edges
	assign rev_c    = !directed_q && (a_q != b_q);
	assign full_c   = (need_fwd_q && (len_a_q >= LW'(MAX_EDGES_PER_NODE))) ||
	                  (need_rev_q && (len_b_q >= LW'(MAX_EDGES_PER_NODE)));
	assign hit_now  = rd_tgt == fn_key_q;
	// cull keeps an edge only if both ends are still active
	assign keep_c   = valid_q[n_q[NW-1:0]] && valid_q[rd_tgt];
	assign load_out = (state_q == gas_pkg::S_DONE) && (!out_valid_q || out_ready);

	assign in_ready     = state_q == gas_pkg::S_IDLE;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found        = found_q;
	assign cost_out     = cost_q;
	assign node_total   = node_total_q;
	assign active_total = active_total_q;
	assign edge_total   = edge_total_q;

	gas_ram #(.WIDTH(LW), .DEPTH(MAX_NODES), .AW(NW)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.raddr (len_raddr),
		.rdata (len_rd)
	);

	gas_ram #(.WIDTH(EDW), .DEPTH(MAX_NODES * MAX_EDGES_PER_NODE), .AW(EA)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (edge_wdata),
		.raddr (edge_raddr),
		.rdata (edge_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gas_pkg::S_IDLE: begin
				if (in_valid) state_d = gas_pkg::S_DECODE;
			end
			gas_pkg::S_DECODE: begin
				unique case (cmd_q)
					gas_pkg::CMD_REM_NODE: begin
						if (a_ok && va)
							state_d = directed_q ? gas_pkg::S_CLEN : gas_pkg::S_RNLEN;
						else
							state_d = gas_pkg::S_DONE;
					end
					gas_pkg::CMD_ADD_EDGE, gas_pkg::CMD_QUERY_EDGE: begin
						state_d = (a_ok && b_ok && va && vb) ? gas_pkg::S_FLEN : gas_pkg::S_DONE;
					end
					gas_pkg::CMD_REM_EDGE, gas_pkg::CMD_SET_COST: begin
						state_d = (a_ok && b_ok) ? gas_pkg::S_FLEN : gas_pkg::S_DONE;
					end
					default: state_d = gas_pkg::S_DONE;
				endcase
			end
			gas_pkg::S_FLEN:  state_d = gas_pkg::S_FLENW;
			gas_pkg::S_FLENW: state_d = gas_pkg::S_FRD;
			gas_pkg::S_FRD:   state_d = (i_q == len_q) ? gas_pkg::S_NEXT : gas_pkg::S_FCMP;
			gas_pkg::S_FCMP:  state_d = hit_now ? gas_pkg::S_NEXT : gas_pkg::S_FRD;
			gas_pkg::S_ERD:   state_d = (LW'(pos_q + 1'b1) < len_q) ? gas_pkg::S_EWR
			                                                         : gas_pkg::S_ELEN;
			gas_pkg::S_EWR:   state_d = gas_pkg::S_ERD;
			gas_pkg::S_ELEN:  state_d = gas_pkg::S_NEXT;
			gas_pkg::S_NEXT: begin
				unique case (cmd_q)
					gas_pkg::CMD_ADD_EDGE: begin
						unique case (ph_q)
							gas_pkg::PH_FIND1: state_d = rev_c ? gas_pkg::S_FLEN : gas_pkg::S_NEXT;
							gas_pkg::PH_FIND2: state_d = gas_pkg::S_NEXT;
							default: begin
								if (full_c || !(need_fwd_q || need_rev_q))
									state_d = gas_pkg::S_DONE;
							end
						endcase
					end
					gas_pkg::CMD_REM_EDGE: begin
						unique case (ph_q)
							gas_pkg::PH_FIND1: state_d = hit_q ? gas_pkg::S_ERD : gas_pkg::S_NEXT;
							gas_pkg::PH_MID:   state_d = gas_pkg::S_FLEN;
							gas_pkg::PH_FIND2: state_d = hit_q ? gas_pkg::S_ERD : gas_pkg::S_NEXT;
							default:           state_d = gas_pkg::S_DONE;
						endcase
					end
					gas_pkg::CMD_REM_NODE: begin
						if (ph_q == gas_pkg::PH_FIND1)
							state_d = hit_q ? gas_pkg::S_ERD : gas_pkg::S_NEXT;
						else
							state_d = gas_pkg::S_RNRD;
					end
					default: state_d = gas_pkg::S_DONE;
				endcase
			end
			gas_pkg::S_RNLEN:  state_d = gas_pkg::S_RNLENW;
			gas_pkg::S_RNLENW: state_d = gas_pkg::S_RNRD;
			gas_pkg::S_RNRD:   state_d = (j_q == rn_len_q) ? gas_pkg::S_RNEND : gas_pkg::S_RNCMP;
			gas_pkg::S_RNCMP:  state_d = (rd_tgt == a_q) ? gas_pkg::S_RNRD : gas_pkg::S_FLEN;
			gas_pkg::S_RNEND:  state_d = gas_pkg::S_DONE;
			gas_pkg::S_CLEN:   state_d = (n_q == slots_q) ? gas_pkg::S_DONE : gas_pkg::S_CLENW;
			gas_pkg::S_CLENW:  state_d = gas_pkg::S_CRD;
			gas_pkg::S_CRD:    state_d = (i_q == len_q) ? gas_pkg::S_CEND : gas_pkg::S_CCHK;
			gas_pkg::S_CCHK:   state_d = gas_pkg::S_CRD;
			gas_pkg::S_CEND:   state_d = gas_pkg::S_CLEN;
			gas_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) state_d = gas_pkg::S_IDLE;
			end
		endcase
	end

	// memory port control
	always_comb begin
		len_we     = 1'b0;
		len_waddr  = fn_node_q;
		len_wdata  = '0;
		len_raddr  = fn_node_q;
		edge_we    = 1'b0;
		edge_waddr = eaddr(fn_node_q, pos_q);
		edge_wdata = edge_rd;
		edge_raddr = eaddr(fn_node_q, i_q);
		unique case (state_q)
			gas_pkg::S_DECODE: begin
				// a fresh slot starts with an empty list
				if (cmd_q == gas_pkg::CMD_ADD_NODE && fresh_c) begin
					len_we    = 1'b1;
					len_waddr = a_q;
				end
			end
			gas_pkg::S_ERD: edge_raddr = eaddr(fn_node_q, LW'(pos_q + 1'b1));
			gas_pkg::S_EWR: edge_we = 1'b1;
			gas_pkg::S_ELEN: begin
				len_we    = 1'b1;
				len_wdata = LW'(len_q - 1'b1);
			end
			gas_pkg::S_NEXT: begin
				if (cmd_q == gas_pkg::CMD_ADD_EDGE && ph_q == gas_pkg::PH_MID && !full_c) begin
					if (need_fwd_q) begin
						len_we     = 1'b1;
						len_waddr  = a_q;
						len_wdata  = LW'(len_a_q + 1'b1);
						edge_we    = 1'b1;
						edge_waddr = eaddr(a_q, len_a_q);
						edge_wdata = {b_q, c_q};
					end else if (need_rev_q) begin
						len_we     = 1'b1;
						len_waddr  = b_q;
						len_wdata  = LW'(len_b_q + 1'b1);
						edge_we    = 1'b1;
						edge_waddr = eaddr(b_q, len_b_q);
						edge_wdata = {a_q, c_q};
					end
				end else if (cmd_q == gas_pkg::CMD_SET_COST && hit_q) begin
					edge_we    = 1'b1;
					edge_waddr = eaddr(a_q, pos_q);
					edge_wdata = {b_q, c_q};
				end
			end
			gas_pkg::S_RNLEN: len_raddr = a_q;
			gas_pkg::S_RNRD:  edge_raddr = eaddr(a_q, j_q);
			gas_pkg::S_RNEND: begin
				len_we    = 1'b1;
				len_waddr = a_q;
			end
			gas_pkg::S_CLEN: len_raddr = n_q[NW-1:0];
			gas_pkg::S_CRD:  edge_raddr = eaddr(n_q[NW-1:0], i_q);
			gas_pkg::S_CCHK: begin
				// compact surviving edges toward the head of the list
				edge_we    = keep_c;
				edge_waddr = eaddr(n_q[NW-1:0], keep_q);
			end
			gas_pkg::S_CEND: begin
				len_we    = 1'b1;
				len_waddr = n_q[NW-1:0];
				len_wdata = keep_q;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gas_pkg::S_IDLE;
			directed_q  <= 1'b0;
			valid_q     <= '0;
			slots_q     <= '0;
			active_q    <= '0;
			edges_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				directed_q <= cfg_wr_data;
			end
			if (state_q == gas_pkg::S_DECODE) begin
				if (cmd_q == gas_pkg::CMD_ADD_NODE) begin
					if (a_ok && !va) begin
						valid_q[a_q] <= 1'b1;
						active_q     <= CW'(active_q + 1'b1);
					end else if (fresh_c) begin
						valid_q[a_q] <= 1'b1;
						slots_q      <= CW'(slots_q + 1'b1);
						active_q     <= CW'(active_q + 1'b1);
					end
				end else if (cmd_q == gas_pkg::CMD_REM_NODE && a_ok && va) begin
					valid_q[a_q] <= 1'b0;
					active_q     <= CW'(active_q - 1'b1);
				end
			end
			unique case (state_q)
				gas_pkg::S_NEXT: begin
					if (cmd_q == gas_pkg::CMD_ADD_EDGE && ph_q == gas_pkg::PH_MID && !full_c &&
					    (need_fwd_q || need_rev_q)) begin
						edges_q <= EW'(edges_q + 1'b1);
					end
				end
				gas_pkg::S_ELEN:  edges_q <= EW'(edges_q - 1'b1);
				gas_pkg::S_RNEND: edges_q <= EW'(edges_q - EW'(rn_len_q));
				gas_pkg::S_CEND:  edges_q <= EW'(edges_q - EW'(LW'(len_q - keep_q)));
				default: begin
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result register
	always_ff @(posedge clk) begin
		unique case (state_q)
			gas_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd_q <= command;
					a_q   <= node_a;
					b_q   <= node_b;
					c_q   <= edge_cost;
					st_q  <= gas_pkg::ST_OK;
					fnd_q <= 1'b0;
					cst_q <= '0;
					any_q <= 1'b0;
				end
			end
			gas_pkg::S_DECODE: begin
				n_q <= '0;
				// undirected remove edge: back edge b->a goes first
				if (cmd_q == gas_pkg::CMD_REM_EDGE && !directed_q) begin
					fn_node_q <= b_q;
					fn_key_q  <= a_q;
				end else begin
					fn_node_q <= a_q;
					fn_key_q  <= b_q;
				end
				ph_q <= (cmd_q == gas_pkg::CMD_REM_EDGE && directed_q) ? gas_pkg::PH_FIND2
				                                                        : gas_pkg::PH_FIND1;
				unique case (cmd_q)
					gas_pkg::CMD_ADD_NODE: begin
						if (a_ok) begin
							if (va) st_q <= gas_pkg::ST_ACTIVE;
						end else if (!fresh_c) begin
							st_q <= gas_pkg::ST_BAD_INDEX;
						end
					end
					gas_pkg::CMD_QUERY_NODE: begin
						if (!a_ok)    st_q  <= gas_pkg::ST_BAD_INDEX;
						else if (!va) st_q  <= gas_pkg::ST_ABSENT;
						else          fnd_q <= 1'b1;
					end
					gas_pkg::CMD_REM_NODE: begin
						if (!a_ok)    st_q <= gas_pkg::ST_BAD_INDEX;
						else if (!va) st_q <= gas_pkg::ST_ABSENT;
					end
					gas_pkg::CMD_ADD_EDGE, gas_pkg::CMD_QUERY_EDGE: begin
						if (!(a_ok && b_ok))  st_q <= gas_pkg::ST_BAD_INDEX;
						else if (!(va && vb)) st_q <= gas_pkg::ST_ABSENT;
					end
					gas_pkg::CMD_REM_EDGE, gas_pkg::CMD_SET_COST: begin
						if (!(a_ok && b_ok)) st_q <= gas_pkg::ST_BAD_INDEX;
					end
					default: st_q <= gas_pkg::ST_BAD_CMD;
				endcase
			end
			gas_pkg::S_FLENW: begin
				len_q <= len_rd;
				i_q   <= '0;
			end
			gas_pkg::S_FRD: begin
				hit_q <= 1'b0;
			end
			gas_pkg::S_FCMP: begin
				if (hit_now) begin
					hit_q  <= 1'b1;
					pos_q  <= i_q;
					hitw_q <= rd_wgt;
				end else begin
					i_q <= LW'(i_q + 1'b1);
				end
			end
			gas_pkg::S_EWR: pos_q <= LW'(pos_q + 1'b1);
			gas_pkg::S_NEXT: begin
				unique case (cmd_q)
					gas_pkg::CMD_ADD_EDGE: begin
						unique case (ph_q)
							gas_pkg::PH_FIND1: begin
								need_fwd_q <= !hit_q;
								len_a_q    <= len_q;
								if (rev_c) begin
									fn_node_q <= b_q;
									fn_key_q  <= a_q;
									ph_q      <= gas_pkg::PH_FIND2;
								end else begin
									need_rev_q <= 1'b0;
									ph_q       <= gas_pkg::PH_MID;
								end
							end
							gas_pkg::PH_FIND2: begin
								need_rev_q <= !hit_q;
								len_b_q    <= len_q;
								ph_q       <= gas_pkg::PH_MID;
							end
							default: begin
								if (full_c)          st_q       <= gas_pkg::ST_FULL;
								else if (need_fwd_q) need_fwd_q <= 1'b0;
								else                 need_rev_q <= 1'b0;
							end
						endcase
					end
					gas_pkg::CMD_REM_EDGE: begin
						unique case (ph_q)
							gas_pkg::PH_FIND1: begin
								if (hit_q) any_q <= 1'b1;
								ph_q <= gas_pkg::PH_MID;
							end
							gas_pkg::PH_MID: begin
								fn_node_q <= a_q;
								fn_key_q  <= b_q;
								ph_q      <= gas_pkg::PH_FIND2;
							end
							gas_pkg::PH_FIND2: begin
								if (hit_q) any_q <= 1'b1;
								ph_q <= gas_pkg::PH_END;
							end
							default: begin
								if (!any_q) st_q <= gas_pkg::ST_ABSENT;
							end
						endcase
					end
					gas_pkg::CMD_SET_COST: begin
						if (!hit_q) st_q <= gas_pkg::ST_ABSENT;
					end
					gas_pkg::CMD_QUERY_EDGE: begin
						if (hit_q) begin
							fnd_q <= 1'b1;
							cst_q <= hitw_q;
						end else begin
							st_q <= gas_pkg::ST_ABSENT;
						end
					end
					gas_pkg::CMD_REM_NODE: begin
						if (ph_q == gas_pkg::PH_FIND1) ph_q <= gas_pkg::PH_MID;
						else                           j_q  <= LW'(j_q + 1'b1);
					end
					default: begin
					end
				endcase
			end
			gas_pkg::S_RNLENW: begin
				rn_len_q <= len_rd;
				j_q      <= '0;
			end
			gas_pkg::S_RNCMP: begin
				// self loop is dropped with the list, no back edge to clear
				if (rd_tgt == a_q) begin
					j_q <= LW'(j_q + 1'b1);
				end else begin
					fn_node_q <= rd_tgt;
					fn_key_q  <= a_q;
					ph_q      <= gas_pkg::PH_FIND1;
				end
			end
			gas_pkg::S_CLENW: begin
				len_q  <= len_rd;
				i_q    <= '0;
				keep_q <= '0;
			end
			gas_pkg::S_CCHK: begin
				if (keep_c) keep_q <= LW'(keep_q + 1'b1);
				i_q <= LW'(i_q + 1'b1);
			end
			gas_pkg::S_CEND: n_q <= CW'(n_q + 1'b1);
			gas_pkg::S_DONE: begin
				if (load_out) begin
					status_q       <= st_q;
					found_q        <= fnd_q;
					cost_q         <= cst_q;
					node_total_q   <= slots_q;
					active_total_q <= active_q;
					edge_total_q   <= edges_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hdl/gas_chk.sv
`timescale 1ns / 1ps

module gas_chk #(
	parameter int MAX_NODES          = 64,
	parameter int MAX_EDGES_PER_NODE = 8,
	parameter int COST_BITS          = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_wr_en,
	input logic                 cfg_wr_data,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [2:0]           command,
	input logic [$clog2(MAX_NODES)-1:0] node_a,
	input logic [$clog2(MAX_NODES)-1:0] node_b,
	input logic [COST_BITS-1:0] edge_cost,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [2:0]           status,
	input logic                 found,
	input logic [COST_BITS-1:0] cost_out,
	input logic [$clog2(MAX_NODES+1)-1:0] node_total,
	input logic [$clog2(MAX_NODES+1)-1:0] active_total,
	input logic [$clog2(MAX_NODES*MAX_EDGES_PER_NODE+1)-1:0] edge_total
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(edge_total))
		else $error("result beat changed while stalled");

	// one command at a time: busy right after an accepted beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accepting a command");

	// active nodes never exceed allocated slots
	a_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> active_total <= node_total)
		else $error("more active nodes than slots");

	// found and a nonzero cost only on a clean status
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (found || cost_out != '0) |-> status == gas_pkg::ST_OK && found)
		else $error("found or cost without ok status");

endmodule

bind graph_adjacency_store gas_chk #(
	.MAX_NODES          (MAX_NODES),
	.MAX_EDGES_PER_NODE (MAX_EDGES_PER_NODE),
	.COST_BITS          (COST_BITS)
) u_gas_chk (.*);

FILE: sim/graph_adjacency_store_test.sv
`timescale 1ns / 1ps

module graph_adjacency_store_test;

	localparam int NODES     = 64;
	localparam int LIST_SIZE = 8;
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [15:0] cost;
		logic [6:0]  node_total;
		logic [6:0]  active_total;
		logic [9:0]  edge_total;
	} graph_reply_t;

	// shadow copy of the graph: predicts one reply per command beat
	class graph_shadow;
		bit          directed;
		bit          valid[NODES];
		int          slots, active, edges;
		int          len[NODES];
		logic [5:0]  tgt[NODES][LIST_SIZE];
		logic [15:0] wt[NODES][LIST_SIZE];
		graph_reply_t replies_due[$];
		int          mismatches;
		int          checked;

		function int pending();
			return replies_due.size();
		endfunction

		function int find(int n, int t);
			for (int i = 0; i < len[n]; i++)
				if (tgt[n][i] == t) return i;
			return -1;
		endfunction

		function bit drop_edge(int n, int t);
			int p;
			p = find(n, t);
			if (p < 0) return 0;
			for (int i = p; i + 1 < len[n]; i++) begin
				tgt[n][i] = tgt[n][i+1];
				wt[n][i]  = wt[n][i+1];
			end
			len[n]--;
			edges--;
			return 1;
		endfunction

		function void push_edge(int n, int t, logic [15:0] c);
			tgt[n][len[n]] = 6'(t);
			wt[n][len[n]]  = c;
			len[n]++;
			edges++;
		endfunction

		// directed mode: keep only edges between two active nodes
		function void cull();
			int keep;
			for (int n = 0; n < slots; n++) begin
				keep = 0;
				for (int i = 0; i < len[n]; i++)
					if (valid[n] && valid[tgt[n][i]]) begin
						tgt[n][keep] = tgt[n][i];
						wt[n][keep]  = wt[n][i];
						keep++;
					end
				edges -= len[n] - keep;
				len[n] = keep;
			end
		endfunction

		function logic [2:0] drop_node(int a);
			logic [5:0] snap[LIST_SIZE];
			int cnt;
			bit dummy;
			if (!valid[a]) return gas_pkg::ST_ABSENT;
			valid[a] = 0;
			active--;
			if (!directed) begin
				cnt = len[a];
				for (int i = 0; i < cnt; i++) snap[i] = tgt[a][i];
				// back-edges go, self loop goes with the list
				for (int i = 0; i < cnt; i++)
					if (snap[i] != a) dummy = drop_edge(snap[i], a);
				edges -= len[a];
				len[a] = 0;
			end else
				cull();
			return gas_pkg::ST_OK;
		endfunction

		function logic [2:0] link(int a, int b, logic [15:0] c);
			bit fwd, rev;
			if (!valid[a] || !valid[b]) return gas_pkg::ST_ABSENT;
			fwd = find(a, b) < 0;
			rev = !directed && a != b && find(b, a) < 0;
			if ((fwd && len[a] >= LIST_SIZE) || (rev && len[b] >= LIST_SIZE))
				return gas_pkg::ST_FULL;
			if (fwd) push_edge(a, b, c);
			if (rev) push_edge(b, a, c);
			return gas_pkg::ST_OK;
		endfunction

		function void accept_command(logic [2:0] cmd, int a, int b, logic [15:0] c);
			graph_reply_t r;
			bit a_ok, b_ok, any;
			int p;
			a_ok = a < slots;
			b_ok = b < slots;
			r = '{gas_pkg::ST_OK, 1'b0, 16'h0, 7'd0, 7'd0, 10'd0};
			case (cmd)
				gas_pkg::CMD_ADD_NODE: begin
					if (a_ok) begin
						if (valid[a]) r.status = gas_pkg::ST_ACTIVE;
						else begin
							valid[a] = 1;
							active++;
						end
					end else if (a == slots && slots < NODES) begin
						valid[a] = 1;
						len[a] = 0;
						slots++;
						active++;
					end else
						r.status = gas_pkg::ST_BAD_INDEX;
				end
				gas_pkg::CMD_REM_NODE: r.status = a_ok ? drop_node(a) : gas_pkg::ST_BAD_INDEX;
				gas_pkg::CMD_ADD_EDGE:
					r.status = (a_ok && b_ok) ? link(a, b, c) : gas_pkg::ST_BAD_INDEX;
				gas_pkg::CMD_REM_EDGE: begin
					if (!(a_ok && b_ok)) r.status = gas_pkg::ST_BAD_INDEX;
					else begin
						any = 0;
						if (!directed && drop_edge(b, a)) any = 1;
						if (drop_edge(a, b)) any = 1;
						r.status = any ? gas_pkg::ST_OK : gas_pkg::ST_ABSENT;
					end
				end
				gas_pkg::CMD_SET_COST: begin
					if (!(a_ok && b_ok)) r.status = gas_pkg::ST_BAD_INDEX;
					else begin
						p = find(a, b);
						if (p < 0) r.status = gas_pkg::ST_ABSENT;
						else wt[a][p] = c;
					end
				end
				gas_pkg::CMD_QUERY_EDGE: begin
					if (!(a_ok && b_ok)) r.status = gas_pkg::ST_BAD_INDEX;
					else if (!valid[a] || !valid[b]) r.status = gas_pkg::ST_ABSENT;
					else begin
						p = find(a, b);
						if (p < 0) r.status = gas_pkg::ST_ABSENT;
						else begin
							r.found = 1;
							r.cost = wt[a][p];
						end
					end
				end
				gas_pkg::CMD_QUERY_NODE: begin
					if (!a_ok) r.status = gas_pkg::ST_BAD_INDEX;
					else if (!valid[a]) r.status = gas_pkg::ST_ABSENT;
					else r.found = 1;
				end
				default: r.status = gas_pkg::ST_BAD_CMD;
			endcase
			r.node_total   = 7'(slots);
			r.active_total = 7'(active);
			r.edge_total   = 10'(edges);
			replies_due.insert(replies_due.size(), r);
		endfunction

		function void compare_result(graph_reply_t got);
			graph_reply_t want;
			checked++;
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat at %0t", $time);
				return;
			end
			want = replies_due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: status %0d/%0d found %0d/%0d cost %h/%h",
						$time, want.status, got.status, want.found, got.found,
						want.cost, got.cost, "  nodes %0d/%0d active %0d/%0d edges %0d/%0d",
						want.node_total, got.node_total, want.active_total,
						got.active_total, want.edge_total, got.edge_total);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_wr_en = 0;
	logic        cfg_wr_data = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [2:0]  command = 0;
	logic [5:0]  node_a = 0;
	logic [5:0]  node_b = 0;
	logic [15:0] edge_cost = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [2:0]  status;
	logic        found;
	logic [15:0] cost_out;
	logic [6:0]  node_total;
	logic [6:0]  active_total;
	logic [9:0]  edge_total;

	graph_shadow shadow = new;
	int  beats_sent;
	int  cmd_seen[8];
	bit  hold_request = 0;
	int  hold_left;
	int  cycle_no;

	always #4 clk = ~clk;

	graph_adjacency_store dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .node_a(node_a), .node_b(node_b), .edge_cost(edge_cost),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found(found), .cost_out(cost_out),
		.node_total(node_total), .active_total(active_total), .edge_total(edge_total)
	);

	// result side: check every accepted beat, then pick the next ready level
	always @(posedge clk) begin
		if (out_valid && out_ready)
			shadow.compare_result('{status, found, cost_out, node_total,
				active_total, edge_total});
		cycle_no++;
		if (hold_left > 0) begin
			// long hold-off: the single result register fills and input stalls
			hold_left--;
			out_ready <= 0;
		end else if (hold_request) begin
			hold_request <= 0;
			hold_left = 400;
			out_ready <= 0;
		end else
			case (cycle_no[8:7])
				2'd0: out_ready <= 1;
				2'd1: out_ready <= $urandom_range(3, 0) != 0;
				2'd2: out_ready <= $urandom_range(3, 0) == 0;
				default: out_ready <= cycle_no[0];
			endcase
	end

	// offer one command beat and hold it until taken
	task automatic issue(logic [2:0] cmd, int a, int b, logic [15:0] c);
		in_valid  <= 1;
		command   <= cmd;
		node_a    <= 6'(a);
		node_b    <= 6'(b);
		edge_cost <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		shadow.accept_command(cmd, a, b, c);
		beats_sent++;
		cmd_seen[cmd]++;
	endtask

	task automatic pause(int cycles);
		in_valid <= 0;
		repeat (cycles) @(posedge clk);
	endtask

	// sender waits for every outstanding result
	task automatic drain();
		in_valid <= 0;
		while (shadow.pending() != 0) @(posedge clk);
	endtask

	task automatic set_mode(bit dir);
		drain();
		repeat (8) @(posedge clk);
		cfg_wr_en   <= 1;
		cfg_wr_data <= dir;
		@(posedge clk);
		cfg_wr_en   <= 0;
		shadow.directed = dir;
	endtask

	// mostly indices near the allocated range, sometimes anything
	function automatic int pick_index(bit tight);
		int top;
		if (shadow.slots == 0 || $urandom_range(7, 0) == 0) return $urandom_range(63, 0);
		top = tight && shadow.slots > 10 ? 9 : shadow.slots;
		if (top > 63) top = 63;
		return $urandom_range(top, 0);
	endfunction

	task automatic random_phase(int count, bit squeeze);
		int burst, a, b;
		logic [2:0] cmd;
		bit tight;
		for (int k = 0; k < count; k++) begin
			if (squeeze && k == 10) hold_request <= 1;
			burst = $urandom_range(11, 0);
			case (burst)
				0, 1, 2: cmd = gas_pkg::CMD_ADD_NODE;
				3:       cmd = gas_pkg::CMD_REM_NODE;
				4, 5, 6: cmd = gas_pkg::CMD_ADD_EDGE;
				7:       cmd = gas_pkg::CMD_REM_EDGE;
				8:       cmd = gas_pkg::CMD_SET_COST;
				9:       cmd = gas_pkg::CMD_QUERY_EDGE;
				10:      cmd = gas_pkg::CMD_QUERY_NODE;
				default: cmd = 3'($urandom_range(7, 0));
			endcase
			tight = $urandom_range(2, 0) == 0;
			a = pick_index(tight);
			b = pick_index(tight);
			if (cmd == gas_pkg::CMD_ADD_NODE && $urandom_range(9, 0) < 6 && shadow.slots < NODES)
				a = shadow.slots;
			issue(cmd, a, b, 16'($urandom_range(16'hffff, 0)));
			// bursts of random length, no gaps at all while squeezing
			if (!squeeze && $urandom_range(5, 0) == 0) pause($urandom_range(6, 1));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		set_mode(0);

		// undirected: bad indices, re-add, mirrored edges, self loop, bad command
		issue(gas_pkg::CMD_QUERY_NODE, 0, 0, 0);
		issue(gas_pkg::CMD_ADD_NODE, 63, 0, 0);
		issue(gas_pkg::CMD_ADD_NODE, 0, 0, 0);
		issue(gas_pkg::CMD_ADD_NODE, 1, 0, 0);
		issue(gas_pkg::CMD_ADD_NODE, 0, 0, 0);
		issue(gas_pkg::CMD_ADD_EDGE, 0, 1, 16'hffff);
		issue(gas_pkg::CMD_ADD_EDGE, 0, 1, 16'h1234);
		issue(gas_pkg::CMD_QUERY_EDGE, 0, 1, 0);
		issue(gas_pkg::CMD_QUERY_EDGE, 1, 0, 0);
		issue(gas_pkg::CMD_SET_COST, 0, 1, 16'h0000);
		issue(gas_pkg::CMD_QUERY_EDGE, 0, 1, 0);
		issue(gas_pkg::CMD_SET_COST, 0, 0, 16'h5555);
		issue(gas_pkg::CMD_ADD_EDGE, 1, 1, 16'haaaa);
		issue(gas_pkg::CMD_REM_EDGE, 1, 0, 0);
		issue(gas_pkg::CMD_REM_EDGE, 1, 0, 0);
		issue(gas_pkg::CMD_REM_EDGE, 0, 63, 0);
		issue(CMD_UNUSED, 63, 63, 16'hffff);
		issue(gas_pkg::CMD_ADD_EDGE, 0, 1, 16'h0100);
		issue(gas_pkg::CMD_REM_NODE, 1, 0, 0);
		issue(gas_pkg::CMD_REM_NODE, 1, 0, 0);
		issue(gas_pkg::CMD_QUERY_NODE, 1, 0, 0);
		issue(gas_pkg::CMD_ADD_EDGE, 0, 1, 16'h0001);
		issue(gas_pkg::CMD_ADD_NODE, 1, 0, 0);
		issue(gas_pkg::CMD_QUERY_EDGE, 1, 1, 0);

		random_phase(110, 0);
		set_mode(1);
		random_phase(110, 1);
		drain();
		random_phase(60, 0);
		set_mode(0);
		random_phase(90, 0);
		set_mode(1);
		random_phase(80, 0);
		drain();

		repeat (50) @(posedge clk);
		$display("%0d command beats, %0d results; add/rem node %0d/%0d, edge cmds %0d",
			beats_sent, shadow.checked, cmd_seen[gas_pkg::CMD_ADD_NODE],
			cmd_seen[gas_pkg::CMD_REM_NODE],
			cmd_seen[gas_pkg::CMD_ADD_EDGE] + cmd_seen[gas_pkg::CMD_REM_EDGE] +
			cmd_seen[gas_pkg::CMD_SET_COST]);
		$display("both edge modes, %0d slots reached, %0d mismatches",
			shadow.slots, shadow.mismatches);
		if (shadow.mismatches == 0 && shadow.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// generous bound on the slowest run
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
